@@ rtl/vtv_pkg.sv @@
// Package for the vertex transform / viewport block: types, constants, codes.
// No dependencies.
package vtv_pkg;

  localparam int unsigned FracBitsDef = 16;

  localparam logic [11:0] LeftRst   = 12'd0;
  localparam logic [11:0] TopRst    = 12'd0;
  localparam logic [12:0] WidthRst  = 13'd640;
  localparam logic [12:0] HeightRst = 13'd480;

  typedef enum logic [1:0] {
    CMD_LOAD_WORLD = 2'd0,
    CMD_LOAD_VP    = 2'd1,
    CMD_VERTEX     = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_TOP    = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAT,
    ST_MAT_ST,
    ST_VTX,
    ST_VTX_ST,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_VP_X,
    ST_VP_Y,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) return 32'sh7fffffff;
    if (v < -68'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

@@ rtl/vtv_div.sv @@
// Serial restoring divider: (num << FRAC) / den, truncated toward zero, saturated.
// Depends on vtv_pkg.
module vtv_div
  import vtv_pkg::*;
#(
  parameter int unsigned FracBits = FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic signed [31:0] den_i,
  output div_ctl_t           ctl_o,
  output logic signed [31:0] quo_o
);
  localparam int unsigned NW = 32 + FracBits;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] rem_n_q, rem_n_d;   // dividend shifting out / quotient shifting in
  logic [32:0]   part_q, part_d;
  logic [31:0]   dmag_q, dmag_d;
  logic          neg_q, neg_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [33:0]   trial;
  logic [NW:0]   qmag;
  logic signed [NW+1:0] qs;

  always_comb begin
    rem_n_d = rem_n_q; part_d = part_q; dmag_d = dmag_q; neg_d = neg_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    trial = {part_q, rem_n_q[NW-1]} - {2'b00, dmag_q};
    if (start_i) begin
      rem_n_d = {(num_i[31] ? 32'(-num_i) : 32'(num_i)), {FracBits{1'b0}}};
      dmag_d  = den_i[31] ? 32'(-den_i) : 32'(den_i);
      neg_d   = num_i[31] ^ den_i[31];
      part_d  = '0;
      cnt_d   = CW'(NW);
      busy_d  = 1'b1;
    end else if (busy_q) begin
      if (!trial[33]) begin
        part_d  = trial[32:0];
        rem_n_d = {rem_n_q[NW-2:0], 1'b1};
      end else begin
        part_d  = {part_q[31:0], rem_n_q[NW-1]};
        rem_n_d = {rem_n_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_n_q <= rem_n_d; part_q <= part_d; dmag_q <= dmag_d; neg_q <= neg_d;
  end

  assign qmag = {1'b0, rem_n_q};
  assign qs   = neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  assign quo_o = sat32(68'(qs));
  assign ctl_o.start = start_i;
  assign ctl_o.done  = done_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without run");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("divider restarted while busy");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q != CW'(1)) |=> busy_q) else $error("divider stopped early");
endmodule

@@ rtl/vertex_transform_viewport_top.sv @@
// Top level: APB registers, coefficient stores, shared multiply-accumulate sequencer.
// Depends on vtv_pkg and vtv_div.
//
// channel   | direction | handshake         | payload
// cmd       | in        | start & !busy     | command, coeff_*, vertex_*
// result    | out       | done_o (1 cycle)  | screen_x, screen_y, depth_z, w_zero
// config    | in        | APB write         | view_left/top/width/height
//
// Load: busy never rises. Vertex: M takes 64 MACs plus one store per element, the
// point four MACs plus one store per element, then 3 divides and the states ST_VP_X,
// ST_VP_Y and ST_DONE; when w is zero the divides and viewport states are skipped.
// Rate is set by the single MAC unit and the one-bit-per-cycle divider.
// Reset clears both matrices (valid bits, one per entry) and sets the registers to their reset values.
// Results cannot be stalled; busy stays high until the cycle done_o rises.
module vertex_transform_viewport_top
  import vtv_pkg::*;
#(
  parameter int unsigned FracBits = FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command_i,
  input  logic [3:0]         coeff_index_i,
  input  logic signed [31:0] coeff_value_i,
  input  logic signed [31:0] vertex_x_i,
  input  logic signed [31:0] vertex_y_i,
  input  logic signed [31:0] vertex_z_i,
  output logic               done_o,
  output logic signed [31:0] screen_x_o,
  output logic signed [31:0] screen_y_o,
  output logic signed [31:0] depth_z_o,
  output logic               w_zero_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  logic [11:0] left_q, top_q;
  logic [12:0] width_q, height_q;
  logic [31:0] wm_q [16];
  logic [31:0] vm_q [16];
  logic [15:0] wv_q, vv_q;
  logic signed [31:0] m_q [16];
  logic signed [31:0] t_q [4];
  logic signed [31:0] v_q [3];
  logic signed [31:0] p_q [3];
  state_e st_q, st_d;
  logic [5:0] cnt_q, cnt_d;   // i,j,k or j,i packed
  logic [1:0] dsel_q, dsel_d;
  logic signed [67:0] acc_q, acc_d;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod_full;
  logic signed [63:0] prod_q;
  logic               prod_v_q;
  logic signed [31:0] sx_q, sy_q, sz_q;
  logic               wz_q, done_q;
  logic               wr, cmd_acc;
  logic               div_start;
  div_ctl_t           dctl;
  logic signed [31:0] dquo;
  logic [1:0] ci, cj, ck;

  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite;
  assign cmd_acc = start & (st_q == ST_IDLE);
  assign busy    = (st_q != ST_IDLE);

  always_comb begin
    case (reg_e'(paddr[3:2]))
      REG_LEFT:   prdata = {20'd0, left_q};
      REG_TOP:    prdata = {20'd0, top_q};
      REG_WIDTH:  prdata = {19'd0, width_q};
      REG_HEIGHT: prdata = {19'd0, height_q};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= LeftRst; top_q <= TopRst; width_q <= WidthRst; height_q <= HeightRst;
      wv_q <= '0; vv_q <= '0;
    end else begin
      if (wr) begin
        case (reg_e'(paddr[3:2]))
          REG_LEFT:   left_q   <= pwdata[11:0];
          REG_TOP:    top_q    <= pwdata[11:0];
          REG_WIDTH:  width_q  <= pwdata[12:0];
          REG_HEIGHT: height_q <= pwdata[12:0];
          default: ;
        endcase
      end
      if (cmd_acc && cmd_e'(command_i) == CMD_LOAD_WORLD) wv_q[coeff_index_i] <= 1'b1;
      if (cmd_acc && cmd_e'(command_i) == CMD_LOAD_VP)    vv_q[coeff_index_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_acc && cmd_e'(command_i) == CMD_LOAD_WORLD) wm_q[coeff_index_i] <= coeff_value_i;
    if (cmd_acc && cmd_e'(command_i) == CMD_LOAD_VP)    vm_q[coeff_index_i] <= coeff_value_i;
    if (cmd_acc) begin
      v_q[0] <= vertex_x_i; v_q[1] <= vertex_y_i; v_q[2] <= vertex_z_i;
    end
  end

  // ST_MAT: cnt = {i,j,k}; ST_VTX: cnt = {j,i}, i==3 adds M row 3 itself
  assign ci = cnt_q[5:4];
  assign cj = cnt_q[3:2];
  assign ck = cnt_q[1:0];

  always_comb begin
    ma = '0; mb = '0;
    case (st_q)
      ST_MAT: begin
        ma = wv_q[{ci, ck}] ? wm_q[{ci, ck}] : '0;
        mb = vv_q[{ck, cj}] ? vm_q[{ck, cj}] : '0;
      end
      ST_VTX: begin
        ma = (cnt_q[1:0] == 2'd3) ? 32'sd1 <<< FracBits : v_q[cnt_q[1:0]];
        mb = m_q[{cnt_q[1:0], cnt_q[3:2]}];
      end
      ST_VP_X: begin ma = p_q[0]; mb = 32'($signed({1'b0, width_q})); end
      // negated after the multiply, so a saturated y does not wrap
      ST_VP_Y: begin ma = p_q[1]; mb = 32'($signed({1'b0, height_q})); end
      default: ;
    endcase
  end
  assign prod_full = 64'(ma) * 64'(mb);

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; dsel_d = dsel_q; acc_d = acc_q; div_start = 1'b0;
    case (st_q)
      ST_IDLE: if (cmd_acc && cmd_e'(command_i) == CMD_VERTEX) begin
        st_d = ST_MAT; cnt_d = '0; acc_d = '0;
      end
      ST_MAT: begin
        if (prod_v_q) acc_d = acc_q + 68'(prod_q >>> FracBits);
        if (ck == 2'd3) st_d = ST_MAT_ST;
        cnt_d = cnt_q + 1'b1;
      end
      ST_MAT_ST: begin
        acc_d = '0;
        if (cnt_q == 6'd0) st_d = ST_VTX;
        else st_d = ST_MAT;
      end
      ST_VTX: begin
        if (prod_v_q) acc_d = acc_q + 68'(prod_q >>> FracBits);
        if (cnt_q[1:0] == 2'd3) st_d = ST_VTX_ST;
        cnt_d = cnt_q + 1'b1;
      end
      ST_VTX_ST: begin
        acc_d = '0;
        if (cnt_q[3:0] == 4'd0) begin st_d = ST_DIV_GO; dsel_d = '0; end
        else st_d = ST_VTX;
      end
      ST_DIV_GO: begin
        if (t_q[3] == '0) st_d = ST_DONE;
        else begin div_start = 1'b1; st_d = ST_DIV_WAIT; end
      end
      ST_DIV_WAIT: if (dctl.done) begin
        if (dsel_q == 2'd2) st_d = ST_VP_X;
        else begin dsel_d = dsel_q + 1'b1; st_d = ST_DIV_GO; end
      end
      ST_VP_X: st_d = ST_VP_Y;
      ST_VP_Y: st_d = ST_DONE;
      ST_DONE: st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // finishing the sum of an element: last product arrives in the _ST state
  logic signed [67:0] fin;
  assign fin = acc_q + 68'(prod_q >>> FracBits);
  logic signed [67:0] vpx, vpy;
  assign vpx = 68'(prod_q >>> 1) + (68'($signed({1'b0, left_q})) <<< FracBits)
             + (68'($signed({1'b0, width_q})) <<< (FracBits - 1));
  assign vpy = ((68'sd0 - 68'(prod_q)) >>> 1) + (68'($signed({1'b0, top_q})) <<< FracBits)
             + (68'($signed({1'b0, height_q})) <<< (FracBits - 1));

  always_ff @(posedge clk_i) begin
    prod_q <= prod_full;
    acc_q  <= acc_d;
    if (st_q == ST_MAT_ST) m_q[cnt_q[5:2] - 4'd1] <= sat32(fin);
    if (st_q == ST_VTX_ST) t_q[cnt_q[3:2] - 2'd1] <= sat32(fin);
    if (st_q == ST_DIV_WAIT && dctl.done) p_q[dsel_q] <= dquo;
    if (st_q == ST_IDLE) wz_q <= 1'b0;
    if (st_q == ST_DIV_GO && t_q[3] == '0) wz_q <= 1'b1;
    if (st_q == ST_VP_Y) sx_q <= sat32(vpx);
    if (st_q == ST_DONE) begin
      sy_q <= wz_q ? '0 : sat32(vpy);
      sz_q <= wz_q ? '0 : p_q[2];
      if (wz_q) sx_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; cnt_q <= '0; dsel_q <= '0; prod_v_q <= 1'b0; done_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; dsel_q <= dsel_d;
      prod_v_q <= (st_q == ST_MAT) || (st_q == ST_VTX);
      done_q <= (st_q == ST_DONE);
    end
  end

  vtv_div #(.FracBits(FracBits)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start),
    .num_i  (t_q[dsel_q]),
    .den_i  (t_q[3]),
    .ctl_o  (dctl),
    .quo_o  (dquo)
  );

  assign done_o     = done_q;
  assign screen_x_o = sx_q;
  assign screen_y_o = sy_q;
  assign depth_z_o  = sz_q;
  assign w_zero_o   = wz_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result held two cycles");
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(st_q == ST_DONE)) else $error("result outside sequence");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> busy) else $error("divide while idle");
endmodule

@@ sim/vertex_transform_viewport_top_tb.sv @@
// Testbench for vertex_transform_viewport_top: matrix loads, vertex transforms and
// viewport settings, checked against an in-bench fixed-point predictor.
// Depends on vtv_pkg and the RTL of the block.
module vertex_transform_viewport_top_tb
  import vtv_pkg::*;
;

  localparam int unsigned Frac = 16;
  localparam int unsigned VertexLatency = 400;
  localparam longint CycleLimit = 1_500_000;

  typedef struct {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] dz;
    logic               wz;
  } screen_pt_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] command_i = CMD_NONE;
  logic [3:0] coeff_index_i = '0;
  logic signed [31:0] coeff_value_i = '0;
  logic signed [31:0] vertex_x_i = '0, vertex_y_i = '0, vertex_z_i = '0;
  logic done_o, w_zero_o;
  logic signed [31:0] screen_x_o, screen_y_o, depth_z_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  vertex_transform_viewport_top i_dut (
    .clk_i, .rst_ni, .start, .busy, .command_i, .coeff_index_i, .coeff_value_i,
    .vertex_x_i, .vertex_y_i, .vertex_z_i, .done_o, .screen_x_o, .screen_y_o,
    .depth_z_o, .w_zero_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .pready
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  longint world_m[16];
  longint vp_m[16];
  longint left_px, top_px, width_px, height_px;
  screen_pt_t pending_pts[$];
  int errors = 0;
  longint cycles = 0;
  int burst_left = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> Frac;
  endfunction

  function automatic screen_pt_t project_vertex(input longint x, input longint y,
                                                input longint z);
    longint m[16];
    longint t[4];
    longint acc, px, py, pz;
    screen_pt_t r;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += qmul(world_m[i*4+k], vp_m[k*4+j]);
        m[i*4+j] = clamp32(acc);
      end
    for (int j = 0; j < 4; j++)
      t[j] = clamp32(m[12+j] + qmul(x, m[j]) + qmul(y, m[4+j]) + qmul(z, m[8+j]));
    if (t[3] == 0) begin
      r.sx = '0; r.sy = '0; r.dz = '0; r.wz = 1'b1;
      return r;
    end
    px = clamp32((t[0] <<< Frac) / t[3]);
    py = clamp32((t[1] <<< Frac) / t[3]);
    pz = clamp32((t[2] <<< Frac) / t[3]);
    r.sx = 32'(clamp32((left_px <<< Frac) + ((px * width_px) >>> 1)
                       + (width_px <<< (Frac - 1))));
    r.sy = 32'(clamp32((top_px <<< Frac) + ((-py * height_px) >>> 1)
                       + (height_px <<< (Frac - 1))));
    r.dz = 32'(pz);
    r.wz = 1'b0;
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("vertex_transform_viewport_top_tb: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    screen_pt_t e;
    if (rst_ni && done_o) begin
      if (pending_pts.size() == 0) begin
        report("unexpected result", screen_x_o, 0);
      end else begin
        e = pending_pts.pop_front();
        if (screen_x_o !== e.sx) report("screen_x", screen_x_o, e.sx);
        if (screen_y_o !== e.sy) report("screen_y", screen_y_o, e.sy);
        if (depth_z_o !== e.dz) report("depth_z", depth_z_o, e.dz);
        if (w_zero_o !== e.wz) report("w_zero", w_zero_o, e.wz);
      end
    end
  end

  // Sends one command; random gaps between bursts.
  task automatic send_cmd(input cmd_e cmd, input logic [3:0] idx, input logic [31:0] cv,
                          input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 12)) @(negedge clk_i);
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    start = 1'b1;
    command_i = cmd; coeff_index_i = idx; coeff_value_i = cv;
    vertex_x_i = x; vertex_y_i = y; vertex_z_i = z;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    case (cmd)
      CMD_LOAD_WORLD: world_m[idx] = longint'($signed(cv));
      CMD_LOAD_VP:    vp_m[idx] = longint'($signed(cv));
      CMD_VERTEX:     pending_pts.push_back(project_vertex($signed(x), $signed(y),
                                                           $signed(z)));
      default: ;
    endcase
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic drain();
    while (pending_pts.size() != 0) @(negedge clk_i);
    repeat (VertexLatency) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_e r, input logic [31:0] val);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = 4'(r) << 2; pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (r)
      REG_LEFT:   left_px = val & 32'hfff;
      REG_TOP:    top_px = val & 32'hfff;
      REG_WIDTH:  width_px = val & 32'h1fff;
      default:    height_px = val & 32'h1fff;
    endcase
  endtask

  task automatic set_viewport(input logic [31:0] l, input logic [31:0] t,
                              input logic [31:0] w, input logic [31:0] h);
    drain();
    write_reg(REG_LEFT, l);
    write_reg(REG_TOP, t);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  function automatic logic [31:0] rand_q(input bit wide);
    if (wide) return $urandom();
    return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
  endfunction

  task automatic load_identity();
    for (int i = 0; i < 16; i++) begin
      send_cmd(CMD_LOAD_WORLD, 4'(i), (i % 5 == 0) ? 32'h10000 : 32'h0, '0, '0, '0);
      send_cmd(CMD_LOAD_VP, 4'(i), (i % 5 == 0) ? 32'h10000 : 32'h0, '0, '0, '0);
    end
  endtask

  // Reset matrices are zero, so w is zero.
  task automatic test_zero_w();
    send_cmd(CMD_VERTEX, 4'hf, 32'hffffffff, 32'h10000, 32'h20000, 32'h30000);
    send_cmd(CMD_NONE, 4'h3, 32'h12345678, 32'h10000, 32'h10000, 32'h10000);
  endtask

  task automatic test_directed();
    load_identity();
    send_cmd(CMD_VERTEX, '0, '0, 32'h8000, 32'hffff8000, 32'h4000);
    send_cmd(CMD_VERTEX, '0, '0, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_cmd(CMD_VERTEX, '0, '0, 32'h80000000, 32'h7fffffff, 32'h80000000);
    // w row scaled to zero gives the flag, then to a small value gives divide overflow
    send_cmd(CMD_LOAD_VP, 4'd15, 32'h0, '0, '0, '0);
    send_cmd(CMD_VERTEX, '0, '0, 32'h10000, 32'h10000, 32'h10000);
    send_cmd(CMD_LOAD_VP, 4'd15, 32'h1, '0, '0, '0);
    send_cmd(CMD_VERTEX, '0, '0, 32'h7fff0000, 32'h80000000, 32'h1);
    send_cmd(CMD_LOAD_WORLD, 4'd0, 32'h7fffffff, '0, '0, '0);
    send_cmd(CMD_LOAD_VP, 4'd0, 32'h80000000, '0, '0, '0);
    send_cmd(CMD_LOAD_VP, 4'd15, 32'h10000, '0, '0, '0);
    send_cmd(CMD_VERTEX, '0, '0, 32'h7fffffff, 32'h0, 32'h0);
    send_cmd(CMD_NONE, '0, '0, 32'h7fffffff, 32'h0, 32'h0);
  endtask

  task automatic test_viewports();
    set_viewport(32'd4095, 32'd4095, 32'd4096, 32'd4096);
    load_identity();
    send_cmd(CMD_VERTEX, '0, '0, 32'h10000, 32'hffff0000, 32'h8000);
    send_cmd(CMD_VERTEX, '0, '0, 32'h7fffffff, 32'h80000000, 32'h0);
    set_viewport(32'd0, 32'd0, 32'd1, 32'd1);
    send_cmd(CMD_VERTEX, '0, '0, 32'hffff8001, 32'h00007fff, 32'h0);
    set_viewport(32'hffffffff, 32'd12, 32'd0, 32'h1fff);
    send_cmd(CMD_VERTEX, '0, '0, 32'h10000, 32'hffff0000, 32'h0);
    send_cmd(CMD_VERTEX, '0, '0, 32'h80000000, 32'h7fffffff, 32'h0);
  endtask

  task automatic test_random(input int n);
    cmd_e c;
    bit wide;
    for (int i = 0; i < n; i++) begin
      if (i % 200 == 100)
        set_viewport($urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(1, 4096), $urandom_range(1, 4096));
      wide = ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 19))
        0:               c = CMD_NONE;
        1,2,3,4,5,6:     c = CMD_LOAD_WORLD;
        7,8,9,10,11,12:  c = CMD_LOAD_VP;
        default:         c = CMD_VERTEX;
      endcase
      send_cmd(c, 4'($urandom()), rand_q(wide), rand_q(wide), rand_q(wide), rand_q(wide));
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) begin
      world_m[i] = 0;
      vp_m[i] = 0;
    end
    left_px = 0; top_px = 0; width_px = 640; height_px = 480;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_zero_w();
    test_directed();
    test_viewports();
    set_viewport(32'd100, 32'd50, 32'd640, 32'd480);
    test_random(800);
    drain();
    if (errors == 0) $display("vertex_transform_viewport_top_tb: clean");
    else $display("vertex_transform_viewport_top_tb: errors");
    $finish;
  end

endmodule
